[rtl/irpd_pkg.sv]
// irpd_pkg: shared types and constants of the IR pulse-distance decoder.
// No dependencies.
package irpd_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned WAKE_W  = 4;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned BITS_W  = 6;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DUR_W-1:0]  THRESH_RST = 16'd750;
  localparam logic [DUR_W-1:0]  SEP_RST    = 16'd10000;
  localparam logic [WAKE_W-1:0] WAKE_RST   = 4'd2;

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_SEP    = 2'd1;
  localparam logic [1:0] REG_WAKE   = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0]  thresh;
    logic [DUR_W-1:0]  sep;
    logic [WAKE_W-1:0] wake;
  } cfg_t;

  typedef enum logic [2:0] {
    STEP_SKIP    = 3'd0,
    STEP_END     = 3'd1,
    STEP_LOW_OK  = 3'd2,
    STEP_LOW_ERR = 3'd3,
    STEP_BIT     = 3'd4
  } step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic       bit_val;
    logic       last;
  } q_entry_t;

endpackage

[rtl/irpd_cfg.sv]
// irpd_cfg: APB-style register file for threshold, separator and wake-up count.
// Depends on irpd_pkg.
module irpd_cfg import irpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh <= THRESH_RST;
      cfg_r.sep    <= SEP_RST;
      cfg_r.wake   <= WAKE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESH: cfg_r.thresh <= pwdata[DUR_W-1:0];
        REG_SEP:    cfg_r.sep    <= pwdata[DUR_W-1:0];
        REG_WAKE:   cfg_r.wake   <= pwdata[WAKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESH: prdata = DATA_W'(cfg_r.thresh);
      REG_SEP:    prdata = DATA_W'(cfg_r.sep);
      REG_WAKE:   prdata = DATA_W'(cfg_r.wake);
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/irpd_front.sv]
// irpd_front: accepts level steps, tracks wake-up position, classifies each step.
// Depends on irpd_pkg.
module irpd_front import irpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             level,
  input  logic [DUR_W-1:0] duration_us,
  input  logic             last_step,
  input  logic             q_full,
  output logic             push,
  output q_entry_t         entry
);

  // saturating at the largest wake-up count is enough for the compare
  logic [WAKE_W-1:0] idx_r, idx_nxt;
  logic              over_th;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign over_th  = duration_us > cfg.thresh;

  always_comb begin
    entry.last    = last_step;
    entry.bit_val = over_th;
    if (idx_r < cfg.wake)          entry.kind = STEP_SKIP;
    else if (duration_us > cfg.sep) entry.kind = STEP_END;
    else if (!level)               entry.kind = over_th ? STEP_LOW_ERR : STEP_LOW_OK;
    else                           entry.kind = STEP_BIT;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (push) begin
      if (last_step)        idx_nxt = '0;
      else if (~&idx_r)     idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule

[rtl/irpd_queue.sv]
// irpd_queue: two-entry queue of classified steps between front and back.
// Depends on irpd_pkg.
module irpd_queue import irpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_data,
  input  logic     pop,
  output q_entry_t rd_data,
  output logic     empty,
  output logic     full
);

  q_entry_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/irpd_back.sv]
// irpd_back: applies classified steps to the burst state, emits a result on the last step.
// Depends on irpd_pkg.
module irpd_back import irpd_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_entry_t          entry,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] code,
  output logic [BITS_W-1:0] bits_received,
  output logic              low_error,
  output logic              separator_seen
);

  localparam int unsigned CNT_W = $clog2(CODE_BITS + 1);

  logic [CODE_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 err_r, err_nxt;
  logic                 end_r, end_nxt;
  logic                 ov_r;
  logic [CODE_W-1:0]    code_r;
  logic [BITS_W-1:0]    bits_r;
  logic                 lerr_r, sep_r;

  assign pop            = !q_empty && (!ov_r || out_ready);
  assign out_valid      = ov_r;
  assign code           = code_r;
  assign bits_received  = bits_r;
  assign low_error      = lerr_r;
  assign separator_seen = sep_r;

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    end_nxt   = end_r;
    if (!end_r) begin
      unique case (entry.kind)
        STEP_END:     end_nxt = 1'b1;
        STEP_LOW_ERR: err_nxt = 1'b1;
        STEP_BIT: begin
          if (cnt_r < CNT_W'(CODE_BITS)) begin
            shift_nxt = {shift_r[CODE_BITS-2:0], entry.bit_val};
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
        STEP_SKIP, STEP_LOW_OK: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      end_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (pop && entry.last) ov_r <= 1'b1;
      else if (out_ready)    ov_r <= 1'b0;
      if (pop) begin
        if (entry.last) begin
          shift_r <= '0;
          cnt_r   <= '0;
          err_r   <= 1'b0;
          end_r   <= 1'b0;
        end else begin
          shift_r <= shift_nxt;
          cnt_r   <= cnt_nxt;
          err_r   <= err_nxt;
          end_r   <= end_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      code_r <= CODE_W'(shift_nxt);
      bits_r <= (32'(cnt_nxt) > 32'd63) ? 6'd63 : BITS_W'(cnt_nxt);
      lerr_r <= err_nxt;
      sep_r  <= end_nxt;
    end
  end

endmodule

[rtl/ir_pulse_distance_decoder.sv]
// ir_pulse_distance_decoder: top level, pulse-distance IR code decoder.
// Depends on irpd_pkg, irpd_cfg, irpd_front, irpd_queue, irpd_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    level, duration_us, last_step
//   out_     output     out_valid/out_ready  code, bits_received, low_error, separator_seen
//   cfg_     input      APB psel/penable     paddr, pwdata, prdata
//
// One step per cycle sustained while out_ready keeps up; a step reaches the back end
// through the queue, and a result is registered as its last step leaves the queue.
// The back end folds each popped step into the burst state in a single update.
// Synchronous active-low reset restores register defaults and clears the burst.
// A stalled result holds the back end; the two-entry queue then fills and drops in_ready.
module ir_pulse_distance_decoder import irpd_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_level,
  input  logic [DUR_W-1:0]  in_duration_us,
  input  logic              in_last_step,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_code,
  output logic [BITS_W-1:0] out_bits_received,
  output logic              out_low_error,
  output logic              out_separator_seen
);

  cfg_t     cfg;
  q_entry_t wr_entry, rd_entry;
  logic     push, pop, q_empty, q_full;

  irpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  irpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .level       (in_level),
    .duration_us (in_duration_us),
    .last_step   (in_last_step),
    .q_full      (q_full),
    .push        (push),
    .entry       (wr_entry)
  );

  irpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .empty   (q_empty),
    .full    (q_full)
  );

  irpd_back #(.CODE_BITS(CODE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .entry          (rd_entry),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code           (out_code),
    .bits_received  (out_bits_received),
    .low_error      (out_low_error),
    .separator_seen (out_separator_seen)
  );

endmodule

[rtl/irpd_checker.sv]
// irpd_checker: port-level assertions for the decoder, bound to the top level.
// Depends on irpd_pkg and ir_pulse_distance_decoder.
module irpd_checker import irpd_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last_step,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BITS_W-1:0] out_bits_received
);

  localparam int unsigned MAX_BITS = (CODE_BITS > 63) ? 63 : CODE_BITS;

  // bursts closed at the input but not yet delivered
  logic [2:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 3'd0;
    else        pend_r <= pend_r + {2'b00, in_valid && in_ready && in_last_step}
                                 - {2'b00, out_valid && out_ready};
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a closed burst");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_bits_received) <= 32'(MAX_BITS))
    else $error("bit count out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind ir_pulse_distance_decoder irpd_checker #(.CODE_BITS(CODE_BITS)) u_irpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_pready        (cfg_pready),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_last_step      (in_last_step),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_bits_received (out_bits_received)
);

[verif/ir_pulse_distance_decoder_tb.sv]
// Self-checking testbench of ir_pulse_distance_decoder: directed and random IR bursts
// under several register settings, results checked against an in-bench burst predictor.
// Depends on irpd_pkg and the decoder RTL.
module ir_pulse_distance_decoder_tb;
  import irpd_pkg::*;

  localparam int unsigned CODE_BITS = 32;
  localparam logic [1:0]  REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] nbits;
    logic              low_err;
    logic              sep_seen;
  } frame_t;

  typedef struct {
    logic             lvl;
    logic [DUR_W-1:0] dur;
  } step_t;

  class frame_checker;
    logic [DUR_W-1:0]  thresh;
    logic [DUR_W-1:0]  sep;
    logic [WAKE_W-1:0] wake;
    logic [7:0]        step_idx;
    logic [63:0]       shift;
    logic [BITS_W-1:0] nbits;
    logic              err;
    logic              ended;
    frame_t            expected_frames[$];
    int                mismatches;

    function new();
      thresh     = THRESH_RST;
      sep        = SEP_RST;
      wake       = WAKE_RST;
      mismatches = 0;
      clear_burst();
    endfunction

    function void clear_burst();
      step_idx = '0;
      shift    = '0;
      nbits    = '0;
      err      = 1'b0;
      ended    = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_THRESH: thresh = val[DUR_W-1:0];
        REG_SEP:    sep    = val[DUR_W-1:0];
        REG_WAKE:   wake   = val[WAKE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_step(logic lvl, logic [DUR_W-1:0] dur, logic last);
      frame_t r;
      if (step_idx >= wake && !ended) begin
        if (dur > sep) begin
          ended = 1'b1;
        end else if (!lvl) begin
          if (dur > thresh) err = 1'b1;
        end else if (nbits < CODE_BITS) begin
          shift = {shift[62:0], dur > thresh};
          nbits = nbits + 1'b1;
        end
      end
      if (step_idx != 8'hFF) step_idx = step_idx + 1'b1;
      if (last) begin
        r.code     = shift[CODE_W-1:0];
        r.nbits    = nbits;
        r.low_err  = err;
        r.sep_seen = ended;
        expected_frames.push_back(r);
        clear_burst();
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_result(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected result: code %h bits %0d err %0b sep %0b",
                         got.code, got.nbits, got.low_err, got.sep_seen));
        return;
      end
      want = expected_frames.pop_front();
      if (got.code !== want.code || got.nbits !== want.nbits ||
          got.low_err !== want.low_err || got.sep_seen !== want.sep_seen)
        report($sformatf("exp code %h bits %0d err %0b sep %0b, got code %h bits %0d err %0b sep %0b",
                         want.code, want.nbits, want.low_err, want.sep_seen,
                         got.code, got.nbits, got.low_err, got.sep_seen));
    endfunction
  endclass

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              cfg_psel       = 1'b0;
  logic              cfg_penable    = 1'b0;
  logic              cfg_pwrite     = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr      = '0;
  logic [DATA_W-1:0] cfg_pwdata     = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              in_level       = 1'b0;
  logic [DUR_W-1:0]  in_duration_us = '0;
  logic              in_last_step   = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CODE_W-1:0] out_code;
  logic [BITS_W-1:0] out_bits_received;
  logic              out_low_error;
  logic              out_separator_seen;

  frame_checker chk = new();
  step_t        burst[$];
  bit           no_idle = 1'b0;
  int           stall_left = 0;
  int           items_sent = 0;
  int           results_sent = 0;

  ir_pulse_distance_decoder #(.CODE_BITS(CODE_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_level           (in_level),
    .in_duration_us     (in_duration_us),
    .in_last_step       (in_last_step),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code           (out_code),
    .out_bits_received  (out_bits_received),
    .out_low_error      (out_low_error),
    .out_separator_seen (out_separator_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("ir_pulse_distance_decoder_tb: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [DUR_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[DUR_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] pick_dur();
    int t;
    int s;
    t = chk.thresh;
    s = chk.sep;
    case ($urandom_range(6, 0))
      0: return '0;
      1: return 16'hFFFF;
      2: return clip(t + int'($urandom_range(2, 0)) - 1);
      3: return clip(s + int'($urandom_range(2, 0)) - 1);
      4: return 16'($urandom);
      default: return 16'($urandom_range(t, 0));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] dur_zero();
    int t;
    t = (chk.thresh < chk.sep) ? chk.thresh : chk.sep;
    return 16'($urandom_range(t, 0));
  endfunction

  function automatic logic [DUR_W-1:0] dur_one();
    if (chk.thresh < chk.sep) return 16'($urandom_range(chk.sep, chk.thresh + 1));
    return pick_dur();
  endfunction

  // result side: random stalls, checks every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chk.check_result('{out_code, out_bits_received, out_low_error, out_separator_seen});
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_step(input logic lvl, input logic [DUR_W-1:0] dur, input logic last);
    int gap;
    in_valid       <= 1'b1;
    in_level       <= lvl;
    in_duration_us <= dur;
    in_last_step   <= last;
    do @(posedge clk); while (!in_ready);
    chk.note_step(lvl, dur, last);
    items_sent++;
    if (last) results_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (chk.expected_frames.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    chk.write_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // only between bursts, with the pipeline empty
  task automatic change_config(input logic [DUR_W-1:0] t, input logic [DUR_W-1:0] s,
                               input logic [WAKE_W-1:0] w);
    stop_sending();
    wait_drain();
    repeat (8) @(posedge clk);
    write_reg(REG_THRESH, {16'($urandom), t});
    write_reg(REG_SEP, {16'($urandom), s});
    write_reg(REG_WAKE, {28'($urandom), w});
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_step(burst[i].lvl, burst[i].dur, i == burst.size() - 1);
  endtask

  task automatic build_frame();
    int r;
    int nbits;
    r = $urandom_range(9, 0);
    if (r < 2) nbits = CODE_BITS;
    else if (r < 3) nbits = $urandom_range(CODE_BITS + 8, CODE_BITS + 1);
    else nbits = $urandom_range(CODE_BITS - 1, 0);
    burst.delete();
    repeat (chk.wake) burst.push_back('{1'($urandom), pick_dur()});
    for (int i = 0; i < nbits; i++) begin
      burst.push_back('{1'b0, ($urandom_range(9, 0) == 0) ? pick_dur() : dur_zero()});
      burst.push_back('{1'b1, $urandom_range(1, 0) ? dur_one() : dur_zero()});
    end
    if ($urandom_range(1, 0) && chk.sep < 16'hFFFF)
      burst.push_back('{1'($urandom), 16'($urandom_range(65535, chk.sep + 1))});
    repeat ($urandom_range(3, 0)) burst.push_back('{1'($urandom), pick_dur()});
    if (burst.size() == 0) burst.push_back('{1'($urandom), pick_dur()});
  endtask

  task automatic build_noise(input int len);
    burst.delete();
    repeat (len) burst.push_back('{1'($urandom), pick_dur()});
  endtask

  initial begin
    int ph;
    int phase_end;
    int r;
    int cut;
    logic [DUR_W-1:0] t;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: wake-up skip, threshold and separator edges, steps after separator
    send_step(1'b1, 16'hFFFF, 1'b1);
    send_step(1'b0, 16'hFFFF, 1'b0);
    send_step(1'b1, 16'hFFFF, 1'b0);
    send_step(1'b1, 16'd751, 1'b0);
    send_step(1'b1, 16'd750, 1'b0);
    send_step(1'b0, 16'd751, 1'b0);
    send_step(1'b0, 16'd0, 1'b0);
    send_step(1'b1, 16'd0, 1'b0);
    send_step(1'b1, 16'd10000, 1'b0);
    send_step(1'b1, 16'd10001, 1'b0);
    send_step(1'b1, 16'd2000, 1'b0);
    send_step(1'b0, 16'd20000, 1'b1);

    change_config(16'd0, 16'hFFFF, 4'd0);
    write_reg(REG_SPARE, $urandom);
    send_step(1'b1, 16'd0, 1'b0);
    send_step(1'b1, 16'd1, 1'b0);
    send_step(1'b0, 16'd0, 1'b0);
    send_step(1'b1, 16'hFFFF, 1'b0);
    send_step(1'b0, 16'd1, 1'b1);

    change_config(16'hFFFF, 16'd0, 4'd1);
    send_step(1'b0, 16'hFFFF, 1'b0);
    send_step(1'b1, 16'd0, 1'b0);
    send_step(1'b0, 16'd0, 1'b0);
    send_step(1'b1, 16'd1, 1'b0);
    send_step(1'b1, 16'd0, 1'b1);

    ph = 0;
    while (items_sent < 600 || results_sent < 40 || ph < 5) begin
      case (ph % 5)
        0: change_config(THRESH_RST, SEP_RST, WAKE_RST);
        1: change_config(16'd0, 16'hFFFF, 4'd15);
        2: change_config(16'hFFFF, 16'd0, 4'd0);
        3: begin
          t = 16'($urandom_range(2000, 300));
          change_config(t, 16'($urandom_range(30000, t + 500)), 4'($urandom_range(4, 0)));
        end
        default: change_config(16'($urandom), 16'($urandom), 4'($urandom));
      endcase
      // long burst: step index saturates
      if (ph == 0) begin
        build_noise(260);
        send_burst();
      end
      phase_end = items_sent + 50;
      while (items_sent < phase_end) begin
        no_idle = ($urandom_range(9, 0) == 0);
        r = $urandom_range(9, 0);
        if (r < 7) begin
          build_frame();
        end else if (r < 9) begin
          build_noise($urandom_range(12, 1));
        end else begin
          build_frame();
          cut = $urandom_range(burst.size(), 1);
          while (burst.size() > cut) void'(burst.pop_back());
        end
        send_burst();
        if ($urandom_range(19, 0) == 0) begin
          stop_sending();
          wait_drain();
        end
      end
      ph++;
    end
    no_idle = 1'b0;

    stop_sending();
    wait_drain();
    repeat (20) @(posedge clk);
    if (chk.mismatches == 0)
      $display("ir_pulse_distance_decoder_tb: PASS");
    else
      $display("ir_pulse_distance_decoder_tb: FAIL");
    $finish;
  end

endmodule
